### rtl/core/xcfp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcfp_pkg
// Shared types and constants of the XOR-checked frame parser.
// ---------------------------------------------------------------------------
package xcfp_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CfgIdxW = 8;

	localparam logic [ByteW-1:0] SyncFirstRst = 8'h3a;
	localparam logic [ByteW-1:0] SyncSecondRst = 8'hc3;

	localparam logic [CfgIdxW-1:0] RegSyncFirst = 8'd0;
	localparam logic [CfgIdxW-1:0] RegSyncSecond = 8'd1;

	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_ID      = 3'd3,
		PH_DST     = 3'd4,
		PH_SRC     = 3'd5,
		PH_PAYLOAD = 3'd6,
		PH_CHECK   = 3'd7
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0] sync_first;
		logic [ByteW-1:0] sync_second;
	} sync_cfg_t;

	typedef struct packed {
		logic             payload_valid;
		logic [ByteW-1:0] payload_byte;
		logic [ByteW-1:0] payload_index;
		logic             frame_done;
		logic             frame_good;
		logic [ByteW-1:0] message_id;
		logic [ByteW-1:0] frame_len;
	} result_t;

endpackage

### rtl/core/xcfp_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcfp_cfg
// Sync byte registers, written through the configuration channel.
// ---------------------------------------------------------------------------
module xcfp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [xcfp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [xcfp_pkg::ByteW-1:0]    cfg_data,
	output xcfp_pkg::sync_cfg_t           cfg
);
	import xcfp_pkg::*;

	logic [ByteW-1:0] sync_first_q;
	logic [ByteW-1:0] sync_second_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SyncFirstRst;
			sync_second_q <= SyncSecondRst;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == RegSyncFirst) begin
				sync_first_q <= cfg_data;
			end
			if (cfg_index == RegSyncSecond) begin
				sync_second_q <= cfg_data;
			end
		end
	end

	assign cfg.sync_first  = sync_first_q;
	assign cfg.sync_second = sync_second_q;

endmodule

### rtl/core/xcfp_deframer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcfp_deframer
// Phase sequencer and XOR checksum; forms one result per accepted word.
// ---------------------------------------------------------------------------
module xcfp_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [xcfp_pkg::ByteW-1:0]  rx_byte,
	input  xcfp_pkg::sync_cfg_t         cfg,
	output xcfp_pkg::result_t           res
);
	import xcfp_pkg::*;

	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] checksum_q, checksum_d;
	logic [ByteW-1:0] length_q, length_d;
	logic [ByteW-1:0] msg_id_q, msg_id_d;
	logic [ByteW-1:0] count_q, count_d;
	logic [ByteW-1:0] count_inc;

	assign count_inc = count_q + 8'd1;

	always_comb begin
		phase_d    = phase_q;
		checksum_d = checksum_q;
		length_d   = length_q;
		msg_id_d   = msg_id_q;
		count_d    = count_q;
		res        = '0;
		unique case (phase_q)
			PH_SYNC1: begin
				if (rx_byte == cfg.sync_first) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase_d = (rx_byte == cfg.sync_second) ? PH_LENGTH : PH_SYNC1;
			end
			PH_LENGTH: begin
				length_d   = rx_byte;
				checksum_d = rx_byte;
				phase_d    = PH_ID;
			end
			PH_ID: begin
				msg_id_d   = rx_byte;
				checksum_d = checksum_q ^ rx_byte;
				phase_d    = PH_DST;
			end
			PH_DST: begin
				checksum_d = checksum_q ^ rx_byte;
				phase_d    = PH_SRC;
			end
			PH_SRC: begin
				checksum_d = checksum_q ^ rx_byte;
				count_d    = '0;
				phase_d    = (length_q == '0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = count_q;
				checksum_d        = checksum_q ^ rx_byte;
				count_d           = count_inc;
				if (count_inc == length_q) phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				res.frame_done = 1'b1;
				res.frame_good = (checksum_q == rx_byte);
				phase_d        = PH_SYNC1;
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
		res.message_id = msg_id_d;
		res.frame_len  = length_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SYNC1;
			checksum_q <= '0;
			length_q   <= '0;
			msg_id_q   <= '0;
			count_q    <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			checksum_q <= checksum_d;
			length_q   <= length_d;
			msg_id_q   <= msg_id_d;
			count_q    <= count_d;
		end
	end

endmodule

### rtl/core/xcfp_out_buf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcfp_out_buf
// Result register with a skid stage; full input rate while out_ready is high.
// ---------------------------------------------------------------------------
module xcfp_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  xcfp_pkg::result_t  push_data,
	output logic               push_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output xcfp_pkg::result_t  out_data
);
	import xcfp_pkg::*;

	result_t main_q, skid_q;
	logic    main_v_q, skid_v_q;
	logic    drain;

	assign push_ready = !skid_v_q;
	assign drain      = !main_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (drain) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = main_v_q;
	assign out_data  = main_q;

endmodule

### rtl/core/xor_checked_frame_parser_core.sv
`timescale 1ns / 1ps
// The result of an accepted word is registered in the output register, or in the
// skid register while out_ready is low; one word per cycle while in_ready is high.
// A skid stage keeps in_ready high for one word after out_ready drops.
// Reset (arst_n low): parser hunts the first sync byte, checksum and counters
// clear, sync bytes return to 0x3a / 0xc3, output buffer empties.
// ---------------------------------------------------------------------------
// xor_checked_frame_parser_core
// Byte-serial deframer with XOR checksum, payload index and frame status.
// ---------------------------------------------------------------------------
module xor_checked_frame_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [xcfp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [xcfp_pkg::ByteW-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [xcfp_pkg::ByteW-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          payload_valid,
	output logic [xcfp_pkg::ByteW-1:0]    payload_byte,
	output logic [xcfp_pkg::ByteW-1:0]    payload_index,
	output logic                          frame_done,
	output logic                          frame_good,
	output logic [xcfp_pkg::ByteW-1:0]    message_id_out,
	output logic [xcfp_pkg::ByteW-1:0]    frame_length_out
);
	import xcfp_pkg::*;

	sync_cfg_t cfg;
	result_t   res;
	result_t   out_res;
	logic      accept;

	assign accept = in_valid && in_ready;

	xcfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	xcfp_deframer u_deframer (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.cfg     (cfg),
		.res     (res)
	);

	xcfp_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (res),
		.push_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_res)
	);

	assign payload_valid    = out_res.payload_valid;
	assign payload_byte     = out_res.payload_byte;
	assign payload_index    = out_res.payload_index;
	assign frame_done       = out_res.frame_done;
	assign frame_good       = out_res.frame_good;
	assign message_id_out   = out_res.message_id;
	assign frame_length_out = out_res.frame_len;

endmodule
